@@ src/round_robin_task_scheduler_macros.svh @@
// Assertion macros for the round-robin scheduler.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH

// Same-cycle implication.
`define RRTS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define RRTS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/rrts_pkg.sv @@
`default_nettype none

package rrts_pkg;

	localparam int QUEUE_DEPTH = 16;

	localparam int ID_W     = 16;
	localparam int TIME_W   = 32;
	localparam int TICK_W   = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W    = 16;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_TICK_LENGTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLICE_LIMIT = 1'b1;

	localparam logic [TICK_W-1:0] TICK_LENGTH_RST = 16'd1;
	localparam logic [TICK_W-1:0] SLICE_LIMIT_RST = 16'd50;

	// Input commands
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_ADD  = 1'b1;

	// One queued or running task
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] length;
		logic [TIME_W-1:0] elapsed;
	} entry_t;

	// One input item
	typedef struct packed {
		logic              command;
		logic [TIME_W-1:0] now_time;
		logic [ID_W-1:0]   new_task_id;
		logic [TIME_W-1:0] new_task_length;
	} item_t;

	// One result item
	typedef struct packed {
		logic              done_flag;
		logic [ID_W-1:0]   done_task_id;
		logic [TIME_W-1:0] done_time;
		logic              started_flag;
		logic              running_flag;
		logic [ID_W-1:0]   running_task_id;
		logic              queue_full_flag;
	} result_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic commit;
	} cmd_t;

	// Datapath status
	typedef struct packed {
		logic cpu_busy;
		logic queue_empty;
		logic queue_full;
	} status_t;

endpackage

`default_nettype wire

@@ src/rrts_if.sv @@
`default_nettype none

// Task request channel
interface rrts_req_if;
	logic                       valid;
	logic                       ready;
	logic                       command;
	logic [rrts_pkg::TIME_W-1:0] now_time;
	logic [rrts_pkg::ID_W-1:0]   new_task_id;
	logic [rrts_pkg::TIME_W-1:0] new_task_length;

	modport source (output valid, command, now_time, new_task_id, new_task_length,
		input ready);
	modport sink (input valid, command, now_time, new_task_id, new_task_length,
		output ready);
endinterface

// Scheduler result channel
interface rrts_rsp_if;
	logic                       valid;
	logic                       ready;
	logic                       done_flag;
	logic [rrts_pkg::ID_W-1:0]   done_task_id;
	logic [rrts_pkg::TIME_W-1:0] done_time;
	logic                       started_flag;
	logic                       running_flag;
	logic [rrts_pkg::ID_W-1:0]   running_task_id;
	logic                       queue_full_flag;

	modport source (output valid, done_flag, done_task_id, done_time, started_flag,
		running_flag, running_task_id, queue_full_flag, input ready);
	modport sink (input valid, done_flag, done_task_id, done_time, started_flag,
		running_flag, running_task_id, queue_full_flag, output ready);
endinterface

`default_nettype wire

@@ src/rrts_ctrl.sv @@
`default_nettype none

module rrts_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output rrts_pkg::cmd_t     cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_LOAD = 3'b010,
		ST_EXEC = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   can_commit;

	// Result slot is free or drains this cycle
	assign can_commit  = !out_valid_q || rsp_ready;
	assign req_ready   = (state_q == ST_IDLE) || ((state_q == ST_EXEC) && can_commit);
	assign cmd.capture = req_valid && req_ready;
	assign cmd.commit  = (state_q == ST_EXEC) && can_commit;
	assign rsp_valid   = out_valid_q;

	// Advance the item sequence
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.capture) state_d = ST_LOAD;
			end
			ST_LOAD: begin
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (cmd.commit) state_d = cmd.capture ? ST_LOAD : ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold the result until the sink takes the transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

@@ src/rrts_dp.sv @@
`default_nettype none

module rrts_dp #(
	parameter int QUEUE_DEPTH = rrts_pkg::QUEUE_DEPTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire rrts_pkg::cmd_t                cmd,
	input  wire rrts_pkg::item_t               item,
	input  wire logic                          cfg_we,
	input  wire logic [rrts_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [rrts_pkg::CFG_W-1:0]     cfg_data,
	output rrts_pkg::result_t                  result,
	output rrts_pkg::status_t                  status
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	localparam int TW = rrts_pkg::TIME_W;
	localparam int SW = rrts_pkg::TICK_W;

	// Ready queue storage
	rrts_pkg::entry_t mem [QUEUE_DEPTH];
	rrts_pkg::entry_t rd_q;

	rrts_pkg::item_t  item_s1;
	rrts_pkg::result_t res_q;

	logic [PTR_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0] count_q;
	logic [SW-1:0]    tick_q, limit_q;

	logic                         busy_q;
	logic [rrts_pkg::ID_W-1:0]     cpu_id_q;
	logic [TW-1:0]                cpu_len_q, cpu_el_q;
	logic [SW-1:0]                cpu_sl_q;

	// Next-state values of one step
	logic                         busy_d;
	logic [rrts_pkg::ID_W-1:0]     cpu_id_d;
	logic [TW-1:0]                cpu_len_d, cpu_el_d;
	logic [SW-1:0]                cpu_sl_d;
	logic                         push, pop;
	rrts_pkg::entry_t             push_e;
	rrts_pkg::result_t            res_d;
	logic [TW:0]                  e_sum;
	logic [SW:0]                  s_sum;
	logic [TW-1:0]                e_sat;
	logic [SW-1:0]                s_sat;
	logic                         q_empty, q_full;

	assign q_empty = (count_q == '0);
	assign q_full  = (count_q >= CNT_FULL);

	// Saturating time update
	assign e_sum = {1'b0, cpu_el_q} + {{(TW + 1 - SW){1'b0}}, tick_q};
	assign s_sum = {1'b0, cpu_sl_q} + {1'b0, tick_q};
	assign e_sat = e_sum[TW] ? {TW{1'b1}} : e_sum[TW-1:0];
	assign s_sat = s_sum[SW] ? {SW{1'b1}} : s_sum[SW-1:0];

	// Work out one step
	always_comb begin
		busy_d    = busy_q;
		cpu_id_d  = cpu_id_q;
		cpu_len_d = cpu_len_q;
		cpu_el_d  = cpu_el_q;
		cpu_sl_d  = cpu_sl_q;
		push      = 1'b0;
		pop       = 1'b0;
		push_e    = '{id: item_s1.new_task_id, length: item_s1.new_task_length,
			elapsed: '0};
		res_d     = '0;

		if (item_s1.command == rrts_pkg::CMD_ADD) begin
			if (q_full) res_d.queue_full_flag = 1'b1;
			else        push = 1'b1;
		end else begin
			if (busy_q) begin
				res_d.started_flag = (cpu_el_q == '0);
				cpu_el_d = e_sat;
				cpu_sl_d = s_sat;
				if (e_sat >= cpu_len_q) begin
					res_d.done_flag    = 1'b1;
					res_d.done_task_id = cpu_id_q;
					res_d.done_time    = item_s1.now_time;
					busy_d    = 1'b0;
					cpu_id_d  = '0;
					cpu_len_d = '0;
					cpu_el_d  = '0;
					cpu_sl_d  = '0;
				end else if (s_sat >= limit_q) begin
					if (q_empty) begin
						cpu_sl_d = '0;
					end else begin
						pop    = 1'b1;
						push   = 1'b1;
						push_e = '{id: cpu_id_q, length: cpu_len_q, elapsed: e_sat};
					end
				end
			end
			if (!busy_d && !q_empty) pop = 1'b1;
		end

		// Dispatch the queue head
		if (pop) begin
			busy_d    = 1'b1;
			cpu_id_d  = rd_q.id;
			cpu_len_d = rd_q.length;
			cpu_el_d  = rd_q.elapsed;
			cpu_sl_d  = '0;
		end

		res_d.running_flag    = busy_d;
		res_d.running_task_id = busy_d ? cpu_id_d : '0;
	end

	// Capture the accepted transaction
	always_ff @(posedge clk) begin
		if (cmd.capture) item_s1 <= item;
	end

	// Queue memory: write at tail, registered read at head
	always_ff @(posedge clk) begin
		if (cmd.commit && push) mem[tail_q] <= push_e;
		rd_q <= mem[head_q];
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.commit) res_q <= res_d;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q  <= rrts_pkg::TICK_LENGTH_RST;
			limit_q <= rrts_pkg::SLICE_LIMIT_RST;
		end else if (cfg_we) begin
			if (cfg_index == rrts_pkg::CFG_TICK_LENGTH)      tick_q  <= cfg_data;
			else if (cfg_index == rrts_pkg::CFG_SLICE_LIMIT) limit_q <= cfg_data;
		end
	end

	// CPU and queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			cpu_id_q  <= '0;
			cpu_len_q <= '0;
			cpu_el_q  <= '0;
			cpu_sl_q  <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
		end else if (cmd.commit) begin
			busy_q    <= busy_d;
			cpu_id_q  <= cpu_id_d;
			cpu_len_q <= cpu_len_d;
			cpu_el_q  <= cpu_el_d;
			cpu_sl_q  <= cpu_sl_d;
			if (pop)  head_q <= (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
			if (push) tail_q <= (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	assign result             = res_q;
	assign status.cpu_busy    = busy_q;
	assign status.queue_empty = q_empty;
	assign status.queue_full  = q_full;

endmodule

`default_nettype wire

@@ src/round_robin_task_scheduler.sv @@
// A result is registered when its item commits, once the item is captured and the
// queue head read; a stalled result channel holds the commit back. A new item is taken
// only as the previous one commits (head read in ST_LOAD, CPU and tail in ST_EXEC).
// Reset (arst_n, asynchronous): CPU idle, queue empty, tick_length 1, slice_limit 50.
// The queue memory is not cleared; only entries holding queued tasks are dispatched.
`default_nettype none
`include "round_robin_task_scheduler_macros.svh"

module round_robin_task_scheduler #(
	parameter int QUEUE_DEPTH = rrts_pkg::QUEUE_DEPTH
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	rrts_req_if.sink                            req,
	rrts_rsp_if.source                          rsp,
	input  wire logic                           cfg_we,
	input  wire logic [rrts_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [rrts_pkg::CFG_W-1:0]     cfg_data
);

	rrts_pkg::cmd_t    cmd;
	rrts_pkg::status_t status;
	rrts_pkg::item_t   item;
	rrts_pkg::result_t result;

	assign item.command         = req.command;
	assign item.now_time        = req.now_time;
	assign item.new_task_id     = req.new_task_id;
	assign item.new_task_length = req.new_task_length;

	rrts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	rrts_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (result),
		.status    (status)
	);

	// Drive the result channel payload
	assign rsp.done_flag       = result.done_flag;
	assign rsp.done_task_id    = result.done_task_id;
	assign rsp.done_time       = result.done_time;
	assign rsp.started_flag    = result.started_flag;
	assign rsp.running_flag    = result.running_flag;
	assign rsp.running_task_id = result.running_task_id;
	assign rsp.queue_full_flag = result.queue_full_flag;

	// Check one item in flight, queue bookkeeping and result consistency
	`RRTS_ASSERT_NXT(a_one_in_flight, req.valid && req.ready, !req.ready, "second item taken while busy")
	`RRTS_ASSERT_IMP(a_queue_sane, 1'b1, !(status.queue_empty && status.queue_full), "queue empty and full")
	`RRTS_ASSERT_IMP(a_add_no_tick, rsp.valid && rsp.queue_full_flag, !rsp.done_flag && !rsp.started_flag, "rejected add also ticked")
	`RRTS_ASSERT_IMP(a_done_clean, rsp.valid && rsp.done_flag, !status.cpu_busy || rsp.running_flag, "done left CPU state inconsistent")

endmodule

`default_nettype wire

@@ tb/sv/round_robin_task_scheduler_tb.sv @@
`timescale 1ns / 1ps

module round_robin_task_scheduler_tb;

	localparam int HOLDOFF_CYCLES = 300;
	localparam int QUIET_LIMIT    = 3000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int PRINT_CAP      = 40;
	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 210;
	localparam int LONG_TICKS     = 6;

	// Random phases, ordered by rising tick length so that leftover tasks stay short
	localparam int PHASE_TICK  [PHASES] = '{1, 1, 3, 7, 250, 1000, 65535, 65535};
	localparam int PHASE_SLICE [PHASES] = '{1, 3, 65535, 20, 0, 2500, 1, 65535};
	localparam int PHASE_ADD   [PHASES] = '{70, 50, 50, 30, 60, 70, 40, 50};

	// One row of the directed table: a register write or a transaction
	typedef struct {
		bit                             is_write;
		logic [rrts_pkg::CFG_IDX_W-1:0] reg_idx;
		logic [rrts_pkg::CFG_W-1:0]     reg_val;
		rrts_pkg::item_t                item;
		bit                             typed;
		rrts_pkg::result_t              typed_res;
	} step_row_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [rrts_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [rrts_pkg::CFG_W-1:0]     cfg_data;

	rrts_req_if req ();
	rrts_rsp_if rsp ();

	round_robin_task_scheduler u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Scheduler shadow state
	rrts_pkg::entry_t waiting_tasks[$];
	rrts_pkg::entry_t running_entry;
	logic             cpu_holds;
	logic [15:0]      cpu_slice;
	logic [15:0]      tick_len  = rrts_pkg::TICK_LENGTH_RST;
	logic [15:0]      slice_lim = rrts_pkg::SLICE_LIMIT_RST;

	// Reports still to arrive, oldest first
	rrts_pkg::result_t report_q[$];
	rrts_pkg::result_t arrived_want;

	int unsigned fault_count   = 0;
	int unsigned quiet_cycles  = 0;
	int unsigned burst_left    = 0;
	int unsigned add_count     = 0;
	int unsigned refused_count = 0;
	int unsigned tick_count    = 0;
	int unsigned finish_count  = 0;
	int unsigned preempt_count = 0;
	int unsigned setting_count = 0;
	int unsigned checked_count = 0;
	bit          steady_flow   = 1'b0;
	bit          holdoff_req   = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Advance the shadow scheduler by one transaction and form its report
	task automatic advance_scheduler(input rrts_pkg::item_t it, output rrts_pkg::result_t res);
		logic [32:0]      elapsed_sum;
		logic [16:0]      slice_sum;
		rrts_pkg::entry_t fresh;
		rrts_pkg::entry_t preempted;
		res = '0;
		if (it.command == rrts_pkg::CMD_ADD) begin
			add_count++;
			if (waiting_tasks.size() >= rrts_pkg::QUEUE_DEPTH) begin
				res.queue_full_flag = 1'b1;
				refused_count++;
			end else begin
				fresh.id      = it.new_task_id;
				fresh.length  = it.new_task_length;
				fresh.elapsed = '0;
				waiting_tasks.push_back(fresh);
			end
		end else begin
			tick_count++;
			if (cpu_holds) begin
				res.started_flag = (running_entry.elapsed == '0);
				elapsed_sum = {1'b0, running_entry.elapsed} + tick_len;
				running_entry.elapsed = elapsed_sum[32] ? '1 : elapsed_sum[31:0];
				slice_sum = {1'b0, cpu_slice} + tick_len;
				cpu_slice = slice_sum[16] ? '1 : slice_sum[15:0];
				if (running_entry.elapsed >= running_entry.length) begin
					res.done_flag    = 1'b1;
					res.done_task_id = running_entry.id;
					res.done_time    = it.now_time;
					cpu_holds     = 1'b0;
					running_entry = '0;
					cpu_slice     = '0;
					finish_count++;
				end else if (cpu_slice >= slice_lim) begin
					// Rotate: take the head first, then requeue the preempted task
					cpu_slice = '0;
					if (waiting_tasks.size() != 0) begin
						preempted     = running_entry;
						running_entry = waiting_tasks.pop_front();
						waiting_tasks.push_back(preempted);
						preempt_count++;
					end
				end
			end
			if (!cpu_holds && waiting_tasks.size() != 0) begin
				running_entry = waiting_tasks.pop_front();
				cpu_slice     = '0;
				cpu_holds     = 1'b1;
			end
		end
		res.running_flag    = cpu_holds;
		res.running_task_id = cpu_holds ? running_entry.id : '0;
	endtask

	// Offer one transaction in bursts with random gaps, then log its report
	task automatic send_item(input rrts_pkg::item_t it, input bit typed,
			input rrts_pkg::result_t typed_res);
		rrts_pkg::result_t predicted;
		int unsigned       gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (steady_flow || $urandom_range(0, 9) < 4)
				gap = 0;
			else if ($urandom_range(0, 9) == 0)
				gap = $urandom_range(8, 20);
			else
				gap = $urandom_range(1, 4);
			if (gap != 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		req.valid           <= 1'b1;
		req.command         <= it.command;
		req.now_time        <= it.now_time;
		req.new_task_id     <= it.new_task_id;
		req.new_task_length <= it.new_task_length;
		do @(posedge clk); while (!req.ready);
		advance_scheduler(it, predicted);
		report_q.push_back(typed ? typed_res : predicted);
	endtask

	// Hold the input until every outstanding report has come back
	task automatic wait_for_reports();
		@(negedge clk);
		req.valid <= 1'b0;
		while (report_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [rrts_pkg::CFG_IDX_W-1:0] idx,
			input logic [rrts_pkg::CFG_W-1:0] val);
		wait_for_reports();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == rrts_pkg::CFG_TICK_LENGTH)
			tick_len = val;
		else
			slice_lim = val;
		setting_count++;
	endtask

	function automatic rrts_pkg::item_t make_tick(input logic [31:0] now);
		rrts_pkg::item_t it;
		it.command         = rrts_pkg::CMD_TICK;
		it.now_time        = now;
		it.new_task_id     = 16'($urandom());
		it.new_task_length = $urandom();
		return it;
	endfunction

	function automatic rrts_pkg::result_t make_report(input logic done,
			input logic [15:0] done_id, input logic [31:0] done_at, input logic started,
			input logic running, input logic [15:0] run_id, input logic full);
		rrts_pkg::result_t res;
		res.done_flag       = done;
		res.done_task_id    = done_id;
		res.done_time       = done_at;
		res.started_flag    = started;
		res.running_flag    = running;
		res.running_task_id = run_id;
		res.queue_full_flag = full;
		return res;
	endfunction

	function automatic step_row_t cmd_row(input logic cmd, input logic [31:0] now,
			input logic [15:0] id, input logic [31:0] len, input bit typed,
			input rrts_pkg::result_t res);
		step_row_t row;
		row.is_write             = 1'b0;
		row.reg_idx              = '0;
		row.reg_val              = '0;
		row.item.command         = cmd;
		row.item.now_time        = now;
		row.item.new_task_id     = id;
		row.item.new_task_length = len;
		row.typed                = typed;
		row.typed_res            = res;
		return row;
	endfunction

	function automatic step_row_t reg_row(input logic [rrts_pkg::CFG_IDX_W-1:0] idx,
			input logic [rrts_pkg::CFG_W-1:0] val);
		step_row_t row;
		row          = cmd_row(rrts_pkg::CMD_TICK, '0, '0, '0, 1'b0, '0);
		row.is_write = 1'b1;
		row.reg_idx  = idx;
		row.reg_val  = val;
		return row;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			fault_count++;
			if (fault_count <= PRINT_CAP)
				$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	// Compare each arriving report with the oldest outstanding one
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			if (report_q.size() == 0) begin
				fault_count++;
				if (fault_count <= PRINT_CAP)
					$display("%0t: report arrived with no transaction outstanding", $time);
			end else begin
				arrived_want = report_q.pop_front();
				checked_count++;
				check_field("done_flag", arrived_want.done_flag, rsp.done_flag);
				check_field("done_task_id", arrived_want.done_task_id, rsp.done_task_id);
				check_field("done_time", arrived_want.done_time, rsp.done_time);
				check_field("started_flag", arrived_want.started_flag, rsp.started_flag);
				check_field("running_flag", arrived_want.running_flag, rsp.running_flag);
				check_field("running_task_id", arrived_want.running_task_id,
					rsp.running_task_id);
				check_field("queue_full_flag", arrived_want.queue_full_flag,
					rsp.queue_full_flag);
			end
		end
	end

	// Abort when no transaction moves on either channel for too long
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
			$display("Mismatches found");
			$finish;
		end
	end

	// Result side: stall patterns, plus one long hold-off on request
	initial begin
		int unsigned span;
		int unsigned mode;
		int unsigned beat;
		logic        take;
		span = 0;
		mode = 0;
		beat = 0;
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holdoff_req) begin
				rsp.ready <= 1'b0;
				repeat (HOLDOFF_CYCLES) @(negedge clk);
				holdoff_req = 1'b0;
				rsp.ready <= 1'b1;
			end else begin
				if (span == 0) begin
					span = $urandom_range(8, 64);
					mode = $urandom_range(0, 3);
				end
				span--;
				beat++;
				case (mode)
					0: take = 1'b1;
					1: take = (beat % 4 != 3);
					2: take = 1'($urandom_range(0, 1));
					default: take = (beat % 5 == 0);
				endcase
				rsp.ready <= take | steady_flow;
			end
		end
	end

	// Stimulus
	initial begin
		step_row_t         rows[$];
		rrts_pkg::item_t   it;
		rrts_pkg::result_t idle_report;
		rrts_pkg::result_t hold0_report;
		int                p;
		int                n;
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = '0;
		cfg_data            = '0;
		req.valid           = 1'b0;
		req.command         = rrts_pkg::CMD_TICK;
		req.now_time        = '0;
		req.new_task_id     = '0;
		req.new_task_length = '0;
		running_entry       = '0;
		cpu_holds           = 1'b0;
		cpu_slice           = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed table
		idle_report  = make_report(0, '0, '0, 0, 0, '0, 0);
		hold0_report = make_report(0, '0, '0, 0, 1, '0, 0);
		rows.push_back(cmd_row(rrts_pkg::CMD_TICK, '0, '0, '0, 1, idle_report));
		rows.push_back(cmd_row(rrts_pkg::CMD_ADD, 32'h1234_5678, 16'hFFFF, '0, 1,
			idle_report));
		// a tick on an idle CPU only dispatches the head
		rows.push_back(cmd_row(rrts_pkg::CMD_TICK, 32'd3, '0, '0, 1,
			make_report(0, '0, '0, 0, 1, 16'hFFFF, 0)));
		// zero length: done on its first tick
		rows.push_back(cmd_row(rrts_pkg::CMD_TICK, '1, '0, '0, 1,
			make_report(1, 16'hFFFF, '1, 1, 0, '0, 0)));
		rows.push_back(cmd_row(rrts_pkg::CMD_ADD, '0, '0, '1, 1, idle_report));
		rows.push_back(cmd_row(rrts_pkg::CMD_ADD, '0, 16'd1, 32'd2, 1, idle_report));
		// adds never dispatch; the next tick fills the idle CPU
		rows.push_back(cmd_row(rrts_pkg::CMD_TICK, 32'd5, '0, '0, 1, hold0_report));
		rows.push_back(reg_row(rrts_pkg::CFG_TICK_LENGTH, '0));
		rows.push_back(reg_row(rrts_pkg::CFG_SLICE_LIMIT, '0));
		// time frozen, zero slice: every tick rotates
		rows.push_back(cmd_row(rrts_pkg::CMD_TICK, 32'd6, '0, '0, 0, '0));
		rows.push_back(cmd_row(rrts_pkg::CMD_TICK, 32'd7, '0, '0, 0, '0));
		rows.push_back(reg_row(rrts_pkg::CFG_TICK_LENGTH, '1));
		rows.push_back(reg_row(rrts_pkg::CFG_SLICE_LIMIT, 16'd1));
		for (n = 1; n <= 15; n++)
			rows.push_back(cmd_row(rrts_pkg::CMD_ADD, $urandom(), 16'(16'h0101 * n),
				32'(n % 3), 1, hold0_report));
		rows.push_back(cmd_row(rrts_pkg::CMD_ADD, '1, 16'hA5A5, 32'd1, 1,
			make_report(0, '0, '0, 0, 1, '0, 1)));
		// preempt with a full queue
		rows.push_back(cmd_row(rrts_pkg::CMD_TICK, 32'd9, '0, '0, 0, '0));
		foreach (rows[i]) begin
			if (rows[i].is_write)
				write_register(rows[i].reg_idx, rows[i].reg_val);
			else
				send_item(rows[i].item, rows[i].typed, rows[i].typed_res);
		end

		// Long task: rotate the short ones out, offset by 3, then a few full-size ticks
		steady_flow = 1'b1;
		while (waiting_tasks.size() != 0)
			send_item(make_tick($urandom()), 0, '0);
		write_register(rrts_pkg::CFG_TICK_LENGTH, 16'd3);
		send_item(make_tick($urandom()), 0, '0);
		write_register(rrts_pkg::CFG_TICK_LENGTH, '1);
		repeat (LONG_TICKS)
			send_item(make_tick($urandom()), 0, '0);
		steady_flow = 1'b0;

		// Random phases
		for (p = 0; p < PHASES; p++) begin
			write_register(rrts_pkg::CFG_TICK_LENGTH, 16'(PHASE_TICK[p]));
			write_register(rrts_pkg::CFG_SLICE_LIMIT, 16'(PHASE_SLICE[p]));
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 5 && n == 60)
					holdoff_req = 1'b1;
				it = make_tick($urandom());
				if ($urandom_range(0, 99) < PHASE_ADD[p]) begin
					it.command         = rrts_pkg::CMD_ADD;
					it.new_task_length = 32'(tick_len) * $urandom_range(0, 30)
						+ $urandom_range(0, tick_len);
				end
				send_item(it, 0, '0);
			end
		end

		wait_for_reports();
		repeat (10) @(posedge clk);
		$display("Covered %0d adds (%0d refused on a full queue) and %0d ticks;",
			add_count, refused_count, tick_count);
		$display("%0d tasks finished, %0d preempted, %0d register writes, %0d reports checked.",
			finish_count, preempt_count, setting_count, checked_count);
		if (fault_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
